[rtl/pss_pkg.sv]
// Package for the preemptive priority scheduler: table entry type,
// sequencer states, request kinds and result status codes.
// No dependencies.
package pss_pkg;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRIO_W = 8;
	localparam int TIME_W = 32;
	localparam int PNUM_W = 5;
	localparam int STAT_W = 2;

	// one above every priority: nothing selected yet
	localparam logic [PRIO_W:0] PRIO_NONE = {1'b1, {PRIO_W{1'b0}}};

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RAN   = 2'd2;
	localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

	typedef struct packed {
		logic [ARR_W-1:0]  arrival;
		logic [BUR_W-1:0]  burst;
		logic [BUR_W-1:0]  remaining;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CUR,
		S_SCAN,
		S_WB,
		S_FIN1,
		S_FIN2,
		S_OUT
	} state_t;

endpackage

[rtl/preemptive_priority_scheduler_unit.sv]
// Preemptive priority scheduler (pss_pkg, pss_table): a sequencer drives one shared comparator
// that walks the process table one entry per cycle through a single registered read port.
// After accept, an add goes straight to S_OUT; a tick reads the running entry (S_CUR) if one
// runs, scans the table (S_SCAN), writes back any pick (S_WB), adds S_FIN1 and S_FIN2 when it
// finishes; then S_OUT. One request at a time, the next taken in S_IDLE after the result registers.
// arst_n clears fill count, time counter, running state and output valid; table is not cleared.
module preemptive_priority_scheduler_unit #(
	parameter int MAX_PROCESSES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,   // arrival_tick[15:0], burst_length[31:16], priority_level[39:32]
	input  logic         s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // process_number[4:0], finish_tick[36:5],
	                                     // turnaround_time[68:37], wait_ticks[100:69], zero pad
	output logic [2:0]   m_axis_tuser    // status[1:0], finished[2]
);

	localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
	localparam int PNUM_W = pss_pkg::PNUM_W;
	localparam int TIME_W = pss_pkg::TIME_W;

	pss_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] time_q;
	logic [IDX_W-1:0]  cur_q;
	logic              cur_valid_q;
	logic [CNT_W-1:0]  scan_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              have_q;

	logic [pss_pkg::PRIO_W:0]  bound_q;
	logic [IDX_W-1:0]          best_q;
	logic [pss_pkg::ARR_W-1:0] best_arr_q;
	logic [pss_pkg::BUR_W-1:0] best_bur_q;
	logic [pss_pkg::BUR_W-1:0] best_rem_q;

	logic [pss_pkg::STAT_W-1:0] res_status_q;
	logic [PNUM_W-1:0]          res_num_q;
	logic                       res_fin_q;
	logic [TIME_W-1:0]          res_ct_q;
	logic [TIME_W-1:0]          res_tat_q;
	logic [TIME_W-1:0]          res_wt_q;
	logic                       m_tvalid_q;

	logic              accept;
	logic              is_add;
	logic              full;
	logic              issue;
	logic              scan_done;
	logic              elig;
	logic              out_free;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [IDX_W-1:0]  mem_raddr;
	pss_pkg::entry_t   mem_wdata;
	pss_pkg::entry_t   rd_data;
	logic [CNT_W-1:0]  count_inc;
	logic [IDX_W:0]    best_num;

	pss_table #(
		.DEPTH(MAX_PROCESSES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	assign s_axis_tready = (state_q == pss_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_add        = (s_axis_tuser == pss_pkg::KIND_ADD);
	assign full          = (count_q == CNT_W'(MAX_PROCESSES));
	assign issue         = (state_q == pss_pkg::S_SCAN) && (scan_q != count_q);
	assign scan_done     = (scan_q == count_q) && !cmp_vld_s1;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign count_inc     = count_q + CNT_W'(1);
	assign best_num      = {1'b0, best_q} + (IDX_W+1)'(1);

	// shared comparator: arrived, work left, strictly more urgent than the bound
	assign elig = cmp_vld_s1 &&
		({{(TIME_W-pss_pkg::ARR_W){1'b0}}, rd_data.arrival} <= time_q) &&
		(rd_data.remaining != '0) &&
		({1'b0, rd_data.prio} < bound_q);

	always_comb begin
		mem_raddr = (state_q == pss_pkg::S_IDLE) ? cur_q : scan_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = best_q;
		mem_wdata = '{arrival: best_arr_q, burst: best_bur_q,
		              remaining: best_rem_q - pss_pkg::BUR_W'(1),
		              prio: bound_q[pss_pkg::PRIO_W-1:0]};
		if (state_q == pss_pkg::S_IDLE) begin
			mem_we    = accept && is_add && !full;
			mem_waddr = count_q[IDX_W-1:0];
			mem_wdata = '{arrival: s_axis_tdata[15:0], burst: s_axis_tdata[31:16],
			              remaining: s_axis_tdata[31:16], prio: s_axis_tdata[39:32]};
		end else if (state_q == pss_pkg::S_WB) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pss_pkg::S_IDLE: begin
				if (accept) begin
					if (is_add)
						state_d = pss_pkg::S_OUT;
					else if (cur_valid_q)
						state_d = pss_pkg::S_CUR;
					else
						state_d = pss_pkg::S_SCAN;
				end
			end
			pss_pkg::S_CUR: state_d = pss_pkg::S_SCAN;
			pss_pkg::S_SCAN: begin
				if (scan_done)
					state_d = have_q ? pss_pkg::S_WB : pss_pkg::S_OUT;
			end
			pss_pkg::S_WB: begin
				state_d = (best_rem_q == pss_pkg::BUR_W'(1)) ? pss_pkg::S_FIN1 : pss_pkg::S_OUT;
			end
			pss_pkg::S_FIN1: state_d = pss_pkg::S_FIN2;
			pss_pkg::S_FIN2: state_d = pss_pkg::S_OUT;
			pss_pkg::S_OUT: begin
				if (out_free)
					state_d = pss_pkg::S_IDLE;
			end
			default: state_d = pss_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pss_pkg::S_IDLE;
			count_q     <= '0;
			time_q      <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			have_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pss_pkg::S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_axis_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				pss_pkg::S_IDLE: begin
					if (accept) begin
						if (is_add && !full)
							count_q <= count_inc;
						cmp_vld_s1 <= 1'b0;
						have_q     <= 1'b0;
						scan_q     <= '0;
					end
				end
				pss_pkg::S_CUR: have_q <= 1'b1;
				pss_pkg::S_SCAN: begin
					cmp_vld_s1 <= issue;
					if (issue)
						scan_q <= scan_q + CNT_W'(1);
					if (elig)
						have_q <= 1'b1;
					if (scan_done && !have_q) begin
						time_q      <= time_q + TIME_W'(1);
						cur_valid_q <= 1'b0;
					end
				end
				pss_pkg::S_WB: begin
					time_q      <= time_q + TIME_W'(1);
					cur_q       <= best_q;
					cur_valid_q <= (best_rem_q != pss_pkg::BUR_W'(1));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pss_pkg::S_IDLE: begin
				if (accept) begin
					bound_q   <= pss_pkg::PRIO_NONE;
					res_fin_q <= 1'b0;
					res_ct_q  <= '0;
					res_tat_q <= '0;
					res_wt_q  <= '0;
					res_num_q <= (is_add && !full) ? PNUM_W'(count_inc) : '0;
					if (is_add)
						res_status_q <= full ? pss_pkg::ST_FULL : pss_pkg::ST_ADDED;
				end
			end
			pss_pkg::S_CUR: begin
				bound_q    <= {1'b0, rd_data.prio};
				best_q     <= cur_q;
				best_arr_q <= rd_data.arrival;
				best_bur_q <= rd_data.burst;
				best_rem_q <= rd_data.remaining;
			end
			pss_pkg::S_SCAN: begin
				cmp_idx_s1 <= scan_q[IDX_W-1:0];
				if (elig) begin
					bound_q    <= {1'b0, rd_data.prio};
					best_q     <= cmp_idx_s1;
					best_arr_q <= rd_data.arrival;
					best_bur_q <= rd_data.burst;
					best_rem_q <= rd_data.remaining;
				end
				if (scan_done && !have_q)
					res_status_q <= pss_pkg::ST_IDLE;
			end
			pss_pkg::S_WB: begin
				res_status_q <= pss_pkg::ST_RAN;
				res_num_q    <= PNUM_W'(best_num);
				if (best_rem_q == pss_pkg::BUR_W'(1)) begin
					res_fin_q <= 1'b1;
					res_ct_q  <= time_q + TIME_W'(1);
				end
			end
			// time_q already holds the completion time here
			pss_pkg::S_FIN1: begin
				res_tat_q <= time_q - {{(TIME_W-pss_pkg::ARR_W){1'b0}}, best_arr_q};
			end
			pss_pkg::S_FIN2: begin
				res_wt_q <= res_tat_q - {{(TIME_W-pss_pkg::BUR_W){1'b0}}, best_bur_q};
			end
			pss_pkg::S_OUT: begin
				if (out_free) begin
					m_axis_tdata <= {3'b000, res_wt_q, res_tat_q, res_ct_q, res_num_q};
					m_axis_tuser <= {res_fin_q, res_status_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROCESSES))
		else $error("process count above table depth");

	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> ({1'b0, cur_q} < (IDX_W+1)'(count_q)))
		else $error("running process outside filled table");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pss_pkg::S_SCAN) |-> (scan_q <= count_q))
		else $error("scan index past fill count");

	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == pss_pkg::ST_RAN))
		else $error("finish flagged on a result where no process ran");

	a_wb_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pss_pkg::S_WB) |-> (best_rem_q != '0))
		else $error("selected process has no work left");
`endif

endmodule

[rtl/pss_table.sv]
// Process table memory: one write port, one read port with registered data.
// Depends on pss_pkg (entry_t).
module pss_table #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  pss_pkg::entry_t            wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output pss_pkg::entry_t            rdata
);

	pss_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[tb/preemptive_priority_scheduler_unit_test.sv]
// Testbench for preemptive_priority_scheduler_unit: directed and random add/tick
// requests, checked against a scoreboard that tracks the process table itself.
// Depends on pss_pkg and the scheduler RTL.
module preemptive_priority_scheduler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH     = 16;
	localparam int STALL_LIMIT     = 2000;
	localparam int RANDOM_REQUESTS = 1300;
	localparam int TAIL_CYCLES     = 40;

	typedef struct {
		logic [pss_pkg::STAT_W-1:0] status;
		logic [pss_pkg::PNUM_W-1:0] pnum;
		logic                       done;
		logic [pss_pkg::TIME_W-1:0] completion;
		logic [pss_pkg::TIME_W-1:0] turnaround;
		logic [pss_pkg::TIME_W-1:0] waiting;
	} sched_result_t;

	class sched_scoreboard;
		logic [pss_pkg::ARR_W-1:0]  arrival [TABLE_DEPTH];
		logic [pss_pkg::BUR_W-1:0]  burst [TABLE_DEPTH];
		logic [pss_pkg::BUR_W-1:0]  remaining [TABLE_DEPTH];
		logic [pss_pkg::PRIO_W-1:0] prio [TABLE_DEPTH];
		int unsigned                fill;
		logic [pss_pkg::TIME_W-1:0] now;
		int unsigned                running_idx;
		bit                         running;
		sched_result_t              results_due[$];
		int unsigned                errors;

		function new();
			fill = 0;
			now = '0;
			running_idx = 0;
			running = 1'b0;
			errors = 0;
		endfunction

		function void note_request(logic kind, logic [pss_pkg::ARR_W-1:0] arr,
				logic [pss_pkg::BUR_W-1:0] bur, logic [pss_pkg::PRIO_W-1:0] pr);
			sched_result_t r;
			int unsigned best;
			int unsigned bound;
			bit have;
			r = '{status: pss_pkg::ST_IDLE, pnum: '0, done: 1'b0,
				completion: '0, turnaround: '0, waiting: '0};
			if (kind == pss_pkg::KIND_ADD) begin
				if (fill < TABLE_DEPTH) begin
					arrival[fill] = arr;
					burst[fill] = bur;
					remaining[fill] = bur;
					prio[fill] = pr;
					fill++;
					r.status = pss_pkg::ST_ADDED;
					r.pnum = pss_pkg::PNUM_W'(fill);
				end else begin
					r.status = pss_pkg::ST_FULL;
				end
			end else begin
				have = 1'b0;
				best = 0;
				bound = 256;
				// running process holds the slot unless someone strictly more urgent shows up
				if (running && running_idx < fill && remaining[running_idx] != '0) begin
					have = 1'b1;
					best = running_idx;
					bound = prio[running_idx];
				end
				for (int i = 0; i < fill; i++) begin
					if ({16'b0, arrival[i]} <= now && remaining[i] != '0 && prio[i] < bound) begin
						bound = prio[i];
						best = i;
						have = 1'b1;
					end
				end
				now = now + 1;
				if (!have) begin
					running = 1'b0;
				end else begin
					running_idx = best;
					running = 1'b1;
					remaining[best] = remaining[best] - 1'b1;
					r.status = pss_pkg::ST_RAN;
					r.pnum = pss_pkg::PNUM_W'(best + 1);
					if (remaining[best] == '0) begin
						r.done = 1'b1;
						r.completion = now;
						r.turnaround = now - {16'b0, arrival[best]};
						r.waiting = r.turnaround - {16'b0, burst[best]};
						running = 1'b0;
					end
				end
			end
			results_due.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task check_result(sched_result_t got);
			sched_result_t want;
			if (results_due.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = results_due.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.pnum !== want.pnum)
					report_mismatch($sformatf("process_number got %0d want %0d",
						got.pnum, want.pnum));
				if (got.done !== want.done)
					report_mismatch($sformatf("finished got %0d want %0d", got.done, want.done));
				if (got.completion !== want.completion)
					report_mismatch($sformatf("finish_tick got %0d want %0d",
						got.completion, want.completion));
				if (got.turnaround !== want.turnaround)
					report_mismatch($sformatf("turnaround_time got %0d want %0d",
						got.turnaround, want.turnaround));
				if (got.waiting !== want.waiting)
					report_mismatch($sformatf("wait_ticks got %0d want %0d",
						got.waiting, want.waiting));
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata = '0;   // arrival_tick[15:0], burst_length[31:16], priority_level[39:32]
	logic         s_axis_tuser = pss_pkg::KIND_TICK; // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;        // process_number[4:0], finish_tick[36:5],
	                                   // turnaround_time[68:37], wait_ticks[100:69], zero pad
	logic [2:0]   m_axis_tuser;        // status[1:0], finished[2]

	sched_scoreboard sb = new();
	sched_result_t   seen;
	int unsigned     burst_left = 0;
	int unsigned     rx_count = 0;
	int unsigned     quiet_cycles = 0;

	preemptive_priority_scheduler_unit #(
		.MAX_PROCESSES(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver: ready pattern rotates through four stall styles
	always @(negedge clk) begin
		rx_count <= rx_count + 1;
		case ((rx_count / 97) % 4)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (rx_count % 8) < 3;
			default: m_axis_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.status = m_axis_tuser[1:0];
			seen.done = m_axis_tuser[2];
			seen.pnum = m_axis_tdata[4:0];
			seen.completion = m_axis_tdata[36:5];
			seen.turnaround = m_axis_tdata[68:37];
			seen.waiting = m_axis_tdata[100:69];
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task send_request(input logic kind, input logic [pss_pkg::ARR_W-1:0] arr,
			input logic [pss_pkg::BUR_W-1:0] bur, input logic [pss_pkg::PRIO_W-1:0] pr);
		int unsigned gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pr, bur, arr};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, arr, bur, pr);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 20);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
	endtask

	task send_random(input logic kind);
		send_request(kind, pss_pkg::ARR_W'($urandom), pss_pkg::BUR_W'($urandom),
			pss_pkg::PRIO_W'($urandom));
	endtask

	// a process that arrives soon, mostly short bursts, often tied priorities
	task add_live_process();
		int unsigned pick;
		logic [pss_pkg::BUR_W-1:0] bur;
		logic [pss_pkg::PRIO_W-1:0] pr;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			bur = '0;
		else if (pick < 12)
			bur = pss_pkg::BUR_W'($urandom_range(100, 300));
		else
			bur = pss_pkg::BUR_W'($urandom_range(1, 40));
		pr = pss_pkg::PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
			: $urandom_range(0, 255));
		send_request(pss_pkg::KIND_ADD, pss_pkg::ARR_W'(sb.now + $urandom_range(0, 30)),
			bur, pr);
	endtask

	initial begin
		int unsigned pick;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, zero burst, far arrival, ties, preemption
		send_request(pss_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00);
		send_request(pss_pkg::KIND_ADD, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(pss_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(pss_pkg::KIND_ADD, 16'd0, 16'd3, 8'd200);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_ADD, 16'd0, 16'd2, 8'd200);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_ADD, 16'd2, 16'd1, 8'd50);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_ADD, 16'd0, 16'd1, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		send_request(pss_pkg::KIND_TICK, 16'd0, 16'd0, 8'd0);
		drain_results();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 400 == 399)
				drain_results();
			pick = $urandom_range(0, 99);
			if (sb.fill < TABLE_DEPTH && pick < 2)
				add_live_process();
			else if (sb.fill == TABLE_DEPTH && pick < 6)
				send_random(pss_pkg::KIND_ADD);
			else
				send_random(pss_pkg::KIND_TICK);
		end

		// make sure the table-full path is taken
		while (sb.fill < TABLE_DEPTH)
			add_live_process();
		send_request(pss_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(pss_pkg::KIND_ADD, 16'h0000, 16'h0000, 8'h00);
		repeat (20) send_random(pss_pkg::KIND_TICK);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
